// File: rtl/olde_pkg.sv
// ----------------------------------------------------------------------------
// olde_pkg
// Shared types and constants for the ordered list delete engine.
// ----------------------------------------------------------------------------
package olde_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned OpW         = 3;
  localparam int unsigned StatusW     = 2;

  typedef enum logic [OpW-1:0] {
    OP_APPEND    = 3'd0,
    OP_DEL_HEAD  = 3'd1,
    OP_DEL_TAIL  = 3'd2,
    OP_DEL_VAL   = 3'd3,
    OP_DEL_AFTER = 3'd4,
    OP_DUMP      = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_DUMP,
    ST_RESP
  } state_e;

endpackage

// File: rtl/ordered_list_delete_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_delete_engine_unit
// Ordered list of signed words with append, delete and dump operations.
// ----------------------------------------------------------------------------
// Timing: append, delete tail, ops on an empty list and unknown codes answer
//   in the cycle after the word is taken; the next is taken when output is free.
// Delete head: one entry moved toward the head per cycle, then the response.
// Delete value / after value: scan through the single read port, then shift the
//   later entries toward the head, then respond.
// Dump: one word per cycle while the output is not stalled. Reset clears the count.
module ordered_list_delete_engine_unit #(
  parameter int unsigned CAPACITY = olde_pkg::CapacityDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [olde_pkg::DataW-1:0]       s_axis_tdata_i,  // [31:0] operand_value
  input  logic [olde_pkg::OpW-1:0]         s_axis_tuser_i,  // [2:0] operation
  // result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [olde_pkg::DataW-1:0]       m_axis_tdata_o,  // [31:0] entry_value
  output logic [olde_pkg::StatusW-1:0]     m_axis_tuser_o,  // [1:0] status
  output logic                             m_axis_tlast_o   // last_of_run
);

  import olde_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapW = CW'(CAPACITY);

  // control state
  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;      // number of valid entries
  logic [CW-1:0]    ptr_q, ptr_d;      // next address to read
  logic [AW-1:0]    rd_addr_q;         // address of the word in the read register
  logic             rd_vld_q, rd_vld_d;
  op_e              op_q;
  logic [DataW-1:0] key_q;
  status_e          resp_q, resp_d;

  // output register
  logic             m_vld_q, m_vld_d;
  logic [DataW-1:0] m_data_q;
  status_e          m_stat_q;
  logic             m_last_q;

  // memory port
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [DataW-1:0] mem_wdata, mem_rdata;

  // datapath controls
  logic             s_fire, out_free, out_load;
  logic [DataW-1:0] out_data;
  status_e          out_stat;
  logic             out_last;
  logic             hit, last_rd, consume;
  logic             cnt_empty, cnt_full;
  op_e              op_in;

  assign op_in     = op_e'(s_axis_tuser_i);
  assign out_free  = !m_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_empty = (cnt_q == '0);
  assign cnt_full  = (cnt_q == CapW);
  assign hit       = rd_vld_q && (mem_rdata == key_q);
  assign last_rd   = rd_vld_q && (CW'(rd_addr_q) == cnt_q - CW'(1));

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire && !cnt_empty) begin
          case (op_in)
            OP_DEL_HEAD:  state_d = ST_SHIFT;
            OP_DEL_VAL:   state_d = ST_SEARCH;
            OP_DEL_AFTER: state_d = ST_SEARCH;
            OP_DUMP:      state_d = ST_DUMP;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          if (op_q == OP_DEL_AFTER && last_rd) begin
            state_d = ST_RESP;   // match is the tail: no successor
          end else begin
            state_d = ST_SHIFT;
          end
        end else if (last_rd) begin
          state_d = ST_RESP;
        end
      end
      ST_SHIFT: begin
        if (ptr_q == cnt_q && !rd_vld_q) begin
          state_d = ST_RESP;
        end
      end
      ST_DUMP: begin
        if (rd_vld_q && out_free && last_rd) begin
          state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    resp_d    = resp_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = s_axis_tdata_i;
    mem_re    = 1'b0;
    consume   = 1'b0;
    out_load  = 1'b0;
    out_data  = '0;
    out_stat  = STAT_OK;
    out_last  = 1'b1;

    case (state_q)
      ST_IDLE: begin
        ptr_d = '0;
        if (s_fire) begin
          out_load = 1'b1;
          case (op_in)
            OP_APPEND: begin
              if (cnt_full) begin
                out_stat = STAT_FULL;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            OP_DEL_HEAD: begin
              if (cnt_empty) begin
                out_stat = STAT_EMPTY;
              end else begin
                out_load = 1'b0;
                ptr_d    = CW'(1);
              end
            end
            OP_DEL_TAIL: begin
              if (cnt_empty) begin
                out_stat = STAT_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            OP_DEL_VAL, OP_DEL_AFTER, OP_DUMP: begin
              if (cnt_empty) begin
                out_stat = STAT_EMPTY;
              end else begin
                out_load = 1'b0;
              end
            end
            default: begin
              out_stat = STAT_OK;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        consume = 1'b1;
        mem_re  = (ptr_q < cnt_q) && !hit;
        if (hit) begin
          if (op_q == OP_DEL_VAL) begin
            ptr_d = CW'(rd_addr_q) + CW'(1);
          end else if (last_rd) begin
            resp_d = STAT_MISSING;
          end else begin
            ptr_d = CW'(rd_addr_q) + CW'(2);
          end
        end else if (last_rd) begin
          resp_d = STAT_MISSING;
        end else if (mem_re) begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      ST_SHIFT: begin
        // move each later entry one place toward the head
        consume = 1'b1;
        mem_re  = (ptr_q < cnt_q);
        if (mem_re) begin
          ptr_d = ptr_q + CW'(1);
        end
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr_q - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (ptr_q == cnt_q && !rd_vld_q) begin
          cnt_d  = cnt_q - CW'(1);
          resp_d = STAT_OK;
        end
      end
      ST_DUMP: begin
        // hold the read word while the output is stalled
        consume = out_free;
        mem_re  = (ptr_q < cnt_q) && (!rd_vld_q || out_free);
        if (mem_re) begin
          ptr_d = ptr_q + CW'(1);
        end
        if (rd_vld_q && out_free) begin
          out_load = 1'b1;
          out_data = mem_rdata;
          out_last = last_rd;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          out_stat = resp_q;
        end
      end
      default: begin
        consume = 1'b1;
      end
    endcase
  end

  assign rd_vld_d = mem_re || (rd_vld_q && !consume);
  assign m_vld_d  = out_load || (m_vld_q && !m_axis_tready_i);

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      m_vld_q  <= 1'b0;
      resp_q   <= STAT_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_vld_d;
      m_vld_q  <= m_vld_d;
      resp_q   <= resp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q  <= op_in;
      key_q <= s_axis_tdata_i;
    end
    if (mem_re) begin
      rd_addr_q <= ptr_q[AW-1:0];
    end
    if (out_load) begin
      m_data_q <= out_data;
      m_stat_q <= out_stat;
      m_last_q <= out_last;
    end
  end

  olde_mem #(
    .Depth (CAPACITY),
    .AddrW (AW),
    .DataW (DataW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_stat_q;
  assign m_axis_tlast_o  = m_last_q;

  // ---------------------------------------------------------------- checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapW)
    else $error("entry count above capacity");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (CW'(rd_addr_q) < cnt_q))
    else $error("read word beyond the valid entries");

  a_rd_scan_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SEARCH || state_q == ST_SHIFT || state_q == ST_DUMP))
    else $error("read word pending outside a scan");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten while full");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_SHIFT) |=> $stable(cnt_q))
    else $error("entry count changed outside append or delete");

endmodule

// File: rtl/olde_mem.sv
// ----------------------------------------------------------------------------
// olde_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module olde_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
